FILE: rtl/core/audio_gain_meter_capture_ring_macros.svh
// Assertion macros for the audio gain meter and capture ring.
`ifndef AUDIO_GAIN_METER_CAPTURE_RING_MACROS_SVH
`define AUDIO_GAIN_METER_CAPTURE_RING_MACROS_SVH

// Condition must hold in the same cycle as its trigger.
`define AGM_ASSERT_NOW(label, clk, rst, trig, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (expr)) \
      else $error("agm assertion failed");

// Condition must hold in the cycle after its trigger.
`define AGM_ASSERT_NEXT(label, clk, rst, trig, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) \
      else $error("agm assertion failed");

`endif

FILE: rtl/core/agm_pkg.sv
// Package: types, constants and codes of the audio gain meter and capture ring.
`default_nettype none

package agm_pkg;

   // ring
   localparam int RING_DEPTH = 16384;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int IDX_W      = RING_AW + 1;

   // buffer accounting
   localparam int MAX_BUFFER_SAMPLES = 4096;
   localparam int CNT_W              = $clog2(MAX_BUFFER_SAMPLES + 1);

   // datapath widths
   localparam int SAMPLE_W    = 16;
   localparam int LEVEL_W     = 15;
   localparam int MAG_W       = SAMPLE_W + 1;
   localparam int GAIN_W      = 16;
   localparam int PROD_W      = MAG_W + GAIN_W;
   localparam int ROUND_SHIFT = 8;
   localparam int SQ_W        = 2 * LEVEL_W;
   localparam int SUM_W       = SQ_W + CNT_W;
   localparam int QUO_W       = SQ_W;
   localparam int ROOT_W      = QUO_W / 2;
   localparam int REM_W       = ROOT_W + 2;
   localparam int SUB_W       = REM_W + 1;
   localparam int DIV_STEPS   = QUO_W;
   localparam int SQRT_STEPS  = ROOT_W;
   localparam int STEP_W      = $clog2(DIV_STEPS);
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int COUNT_W     = 32;

   typedef logic [STEP_W-1:0]    agm_step_type;
   typedef logic [CSR_IDX_W-1:0] agm_csr_idx_type;

   // commands
   localparam logic [1:0] CMD_PUSH  = 2'd0;
   localparam logic [1:0] CMD_POP   = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // register indexes
   localparam agm_csr_idx_type REG_GAIN       = 2'd0;
   localparam agm_csr_idx_type REG_THRESHOLD  = 2'd1;
   localparam agm_csr_idx_type REG_MIN_SPEECH = 2'd2;

   // register reset values
   localparam logic [GAIN_W-1:0]  GAIN_RESET       = 16'd256;
   localparam logic [LEVEL_W-1:0] THRESHOLD_RESET  = 15'd98;
   localparam logic [COUNT_W-1:0] MIN_SPEECH_RESET = 32'd1600;

   typedef struct packed {
      logic [1:0]                 cmd;
      logic signed [SAMPLE_W-1:0] sample_in;
      logic                       buffer_end;
   } agm_req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       sample_valid;
      logic [LEVEL_W-1:0]         rms_level;
      logic [LEVEL_W-1:0]         session_peak;
      logic                       overrun;
      logic [COUNT_W-1:0]         frame_count;
      logic [COUNT_W-1:0]         speech_count;
      logic                       enough_speech;
      logic [LEVEL_W-1:0]         ring_fill;
   } agm_rsp_type;

   // sequencer <-> divide/root unit
   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] dividend;
      logic [CNT_W-1:0] divisor;
   } agm_root_req_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } agm_root_rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_GAIN,
      S_ROUND,
      S_SQUARE,
      S_ACCUM,
      S_ROOT,
      S_POP,
      S_REPLY
   } agm_state_type;

   typedef enum logic [1:0] {
      RD_IDLE,
      RD_DIV,
      RD_SQRT
   } agm_rd_state_type;

endpackage

`default_nettype wire

FILE: rtl/core/agm_ring_ram.sv
// Capture ring storage: one write port, one registered read port.
`default_nettype none

module agm_ring_ram (
   input  wire logic                         clock,
   input  wire logic                         wr_en,
   input  wire logic [agm_pkg::RING_AW-1:0]  wr_addr,
   input  wire logic [agm_pkg::SAMPLE_W-1:0] wr_data,
   input  wire logic                         rd_en,
   input  wire logic [agm_pkg::RING_AW-1:0]  rd_addr,
   output logic      [agm_pkg::SAMPLE_W-1:0] rd_data
);

   logic [agm_pkg::SAMPLE_W-1:0] mem [agm_pkg::RING_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/agm_mult.sv
// Shared registered multiplier: gain scaling and squaring.
`default_nettype none

module agm_mult (
   input  wire logic                       clock,
   input  wire logic [agm_pkg::MAG_W-1:0]  op_a,
   input  wire logic [agm_pkg::GAIN_W-1:0] op_b,
   output logic      [agm_pkg::PROD_W-1:0] product
);

   logic [agm_pkg::PROD_W-1:0] product_ff;

   always_ff @(posedge clock) begin
      product_ff <= agm_pkg::PROD_W'(op_a) * agm_pkg::PROD_W'(op_b);
   end

   assign product = product_ff;

endmodule

`default_nettype wire

FILE: rtl/core/agm_root_div.sv
// Iterative mean and root unit: restoring divide, then digit-by-digit isqrt,
// both stepping through one shared subtractor.
`default_nettype none

module agm_root_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire agm_pkg::agm_root_req_type req,
   output agm_pkg::agm_root_rsp_type      rsp
);

   agm_pkg::agm_rd_state_type       state_ff, state_in;
   agm_pkg::agm_step_type           step_ff, step_in;
   logic [agm_pkg::REM_W-1:0]       rem_ff, rem_in;
   logic [agm_pkg::QUO_W-1:0]       dq_ff, dq_in;
   logic [agm_pkg::ROOT_W-1:0]      root_ff, root_in;
   logic [agm_pkg::CNT_W-1:0]       divisor_ff, divisor_in;
   logic                            done_ff, done_in;

   logic [agm_pkg::SUB_W-1:0]       sub_a;
   logic [agm_pkg::SUB_W-1:0]       sub_b;
   logic [agm_pkg::SUB_W:0]         diff;
   logic                            ge;

   // the shared subtractor
   assign diff = {1'b0, sub_a} - {1'b0, sub_b};
   assign ge   = ~diff[agm_pkg::SUB_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= agm_pkg::RD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      rem_ff     <= rem_in;
      dq_ff      <= dq_in;
      root_ff    <= root_in;
      divisor_ff <= divisor_in;
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      rem_in     = rem_ff;
      dq_in      = dq_ff;
      root_in    = root_ff;
      divisor_in = divisor_ff;
      done_in    = 1'b0;
      sub_a      = '0;
      sub_b      = '0;

      unique case (state_ff)
         agm_pkg::RD_IDLE: begin
            if (req.start) begin
               // quotient fits QUO_W bits, so the top dividend bits start
               // as the partial remainder
               rem_in     = agm_pkg::REM_W'(req.dividend[agm_pkg::SUM_W-1:agm_pkg::QUO_W]);
               dq_in      = req.dividend[agm_pkg::QUO_W-1:0];
               divisor_in = req.divisor;
               step_in    = agm_pkg::agm_step_type'(agm_pkg::DIV_STEPS - 1);
               state_in   = agm_pkg::RD_DIV;
            end
         end
         agm_pkg::RD_DIV: begin
            sub_a = agm_pkg::SUB_W'({rem_ff[agm_pkg::CNT_W-1:0], dq_ff[agm_pkg::QUO_W-1]});
            sub_b = agm_pkg::SUB_W'(divisor_ff);
            rem_in = ge ? agm_pkg::REM_W'(diff[agm_pkg::CNT_W-1:0])
                        : agm_pkg::REM_W'(sub_a[agm_pkg::CNT_W-1:0]);
            dq_in  = {dq_ff[agm_pkg::QUO_W-2:0], ge};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               // quotient now sits in dq; it becomes the radicand
               rem_in   = '0;
               root_in  = '0;
               step_in  = agm_pkg::agm_step_type'(agm_pkg::SQRT_STEPS - 1);
               state_in = agm_pkg::RD_SQRT;
            end
         end
         agm_pkg::RD_SQRT: begin
            sub_a   = {rem_ff[agm_pkg::REM_W-2:0], dq_ff[agm_pkg::QUO_W-1 -: 2]};
            sub_b   = agm_pkg::SUB_W'({root_ff, 2'b01});
            rem_in  = ge ? diff[agm_pkg::REM_W-1:0] : sub_a[agm_pkg::REM_W-1:0];
            root_in = {root_ff[agm_pkg::ROOT_W-2:0], ge};
            dq_in   = {dq_ff[agm_pkg::QUO_W-3:0], 2'b00};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               done_in  = 1'b1;
               state_in = agm_pkg::RD_IDLE;
            end
         end
         default: begin
            state_in = agm_pkg::RD_IDLE;
         end
      endcase
   end

   assign rsp.done = done_ff;
   assign rsp.root = root_ff;

endmodule

`default_nettype wire

FILE: rtl/core/audio_gain_meter_capture_ring.sv
// Top level: audio gain, RMS and peak meter, speech counters and capture ring.
// Push: the result follows the gain multiply, round, square and accumulate
//   steps; a push that closes a buffer also runs the divide (30 steps)
//   and the integer root (15 steps) in the shared subtract unit.
// Pop: registered ring read. Clear and unused commands go straight to reply.
// One item at a time; req_ready returns the cycle after the result is loaded.
// Reset is synchronous and clears all status at once; ring data is not cleared.
`default_nettype none
`include "audio_gain_meter_capture_ring_macros.svh"

module audio_gain_meter_capture_ring (
   input  wire logic                           clock,
   input  wire logic                           reset,

   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire agm_pkg::agm_req_type           req_data,

   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output agm_pkg::agm_rsp_type                rsp_data,

   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire agm_pkg::agm_csr_idx_type       csr_index,
   input  wire logic [agm_pkg::CSR_DATA_W-1:0] csr_data
);

   // --------------------------------------------------------------------
   // State
   // --------------------------------------------------------------------
   agm_pkg::agm_state_type             state_ff, state_in;

   // configuration
   logic [agm_pkg::GAIN_W-1:0]         gain_ff, gain_in;
   logic [agm_pkg::LEVEL_W-1:0]        thresh_ff, thresh_in;
   logic [agm_pkg::COUNT_W-1:0]        min_speech_ff, min_speech_in;

   // ring pointers, counting modulo twice the depth
   logic [agm_pkg::IDX_W-1:0]          wr_idx_ff, wr_idx_in;
   logic [agm_pkg::IDX_W-1:0]          rd_idx_ff, rd_idx_in;

   // meters
   logic [agm_pkg::SUM_W-1:0]          sum_ff, sum_in;
   logic [agm_pkg::CNT_W-1:0]          samples_ff, samples_in;
   logic [agm_pkg::LEVEL_W-1:0]        bpeak_ff, bpeak_in;
   logic [agm_pkg::LEVEL_W-1:0]        level_ff, level_in;
   logic [agm_pkg::LEVEL_W-1:0]        peak_ff, peak_in;
   logic [agm_pkg::COUNT_W-1:0]        frames_ff, frames_in;
   logic [agm_pkg::COUNT_W-1:0]        speech_ff, speech_in;
   logic                               overrun_ff, overrun_in;

   // per-item working registers
   logic                               neg_ff, neg_in;
   logic [agm_pkg::MAG_W-1:0]          mag_ff, mag_in;
   logic                               last_ff, last_in;
   logic [agm_pkg::LEVEL_W-1:0]        r_ff, r_in;
   logic [agm_pkg::SAMPLE_W-1:0]       pop_data_ff, pop_data_in;
   logic                               pop_valid_ff, pop_valid_in;

   // result register
   logic                               rsp_valid_ff, rsp_valid_in;
   agm_pkg::agm_rsp_type               rsp_data_ff, rsp_data_in;
   logic                               rsp_load;

   // shared multiplier
   logic [agm_pkg::MAG_W-1:0]          mul_a;
   logic [agm_pkg::GAIN_W-1:0]         mul_b;
   logic [agm_pkg::PROD_W-1:0]         product;

   // ring memory
   logic                               ram_we;
   logic [agm_pkg::SAMPLE_W-1:0]       ram_wdata;
   logic                               ram_re;
   logic [agm_pkg::SAMPLE_W-1:0]       ram_rdata;

   // divide / root unit
   agm_pkg::agm_root_req_type          root_req;
   agm_pkg::agm_root_rsp_type          root_rsp;

   // helpers
   logic [agm_pkg::IDX_W-1:0]          fill;
   logic                               ring_full;
   logic [agm_pkg::PROD_W:0]           rounded;
   logic                               sat;
   logic [agm_pkg::SUM_W-1:0]          sum_next;
   logic [agm_pkg::CNT_W-1:0]          samples_next;
   logic [agm_pkg::LEVEL_W-1:0]        bpeak_next;
   logic                               finish;

   assign fill      = wr_idx_ff - rd_idx_ff;
   assign ring_full = fill[agm_pkg::IDX_W-1];

   // round to nearest (ties away from zero on the magnitude), then saturate
   assign rounded = {1'b0, product} + (agm_pkg::PROD_W+1)'(1 << (agm_pkg::ROUND_SHIFT - 1));
   assign sat     = |rounded[agm_pkg::PROD_W:agm_pkg::ROUND_SHIFT + agm_pkg::LEVEL_W];

   assign sum_next     = sum_ff + agm_pkg::SUM_W'(product[agm_pkg::SQ_W-1:0]);
   assign samples_next = samples_ff + 1'b1;
   assign bpeak_next   = (r_ff > bpeak_ff) ? r_ff : bpeak_ff;
   assign finish       = last_ff ||
                         (samples_next >= agm_pkg::CNT_W'(agm_pkg::MAX_BUFFER_SAMPLES));

   // stored sample keeps the input sign
   assign ram_wdata = neg_ff ? (agm_pkg::SAMPLE_W'(0) - {1'b0, r_ff}) : {1'b0, r_ff};

   // --------------------------------------------------------------------
   // Sub-units
   // --------------------------------------------------------------------
   agm_mult u_mult (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (product)
   );

   agm_ring_ram u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_idx_ff[agm_pkg::RING_AW-1:0]),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (rd_idx_ff[agm_pkg::RING_AW-1:0]),
      .rd_data (ram_rdata)
   );

   agm_root_div u_root (
      .clock (clock),
      .reset (reset),
      .req   (root_req),
      .rsp   (root_rsp)
   );

   // --------------------------------------------------------------------
   // Registers
   // --------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= agm_pkg::S_IDLE;
         gain_ff       <= agm_pkg::GAIN_RESET;
         thresh_ff     <= agm_pkg::THRESHOLD_RESET;
         min_speech_ff <= agm_pkg::MIN_SPEECH_RESET;
         wr_idx_ff     <= '0;
         rd_idx_ff     <= '0;
         sum_ff        <= '0;
         samples_ff    <= '0;
         bpeak_ff      <= '0;
         level_ff      <= '0;
         peak_ff       <= '0;
         frames_ff     <= '0;
         speech_ff     <= '0;
         overrun_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         gain_ff       <= gain_in;
         thresh_ff     <= thresh_in;
         min_speech_ff <= min_speech_in;
         wr_idx_ff     <= wr_idx_in;
         rd_idx_ff     <= rd_idx_in;
         sum_ff        <= sum_in;
         samples_ff    <= samples_in;
         bpeak_ff      <= bpeak_in;
         level_ff      <= level_in;
         peak_ff       <= peak_in;
         frames_ff     <= frames_in;
         speech_ff     <= speech_in;
         overrun_ff    <= overrun_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      last_ff      <= last_in;
      r_ff         <= r_in;
      pop_data_ff  <= pop_data_in;
      pop_valid_ff <= pop_valid_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // --------------------------------------------------------------------
   // Configuration writes (taken any time; read by the push and reply steps, not while idle)
   // --------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_comb begin
      gain_in       = gain_ff;
      thresh_in     = thresh_ff;
      min_speech_in = min_speech_ff;
      if (csr_valid) begin
         unique case (csr_index)
            agm_pkg::REG_GAIN:       gain_in       = csr_data[agm_pkg::GAIN_W-1:0];
            agm_pkg::REG_THRESHOLD:  thresh_in     = csr_data[agm_pkg::LEVEL_W-1:0];
            agm_pkg::REG_MIN_SPEECH: min_speech_in = csr_data[agm_pkg::COUNT_W-1:0];
            default: ;  // unused index, write dropped
         endcase
      end
   end

   // --------------------------------------------------------------------
   // Sequencer: next state and datapath control
   // --------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      wr_idx_in    = wr_idx_ff;
      rd_idx_in    = rd_idx_ff;
      sum_in       = sum_ff;
      samples_in   = samples_ff;
      bpeak_in     = bpeak_ff;
      level_in     = level_ff;
      peak_in      = peak_ff;
      frames_in    = frames_ff;
      speech_in    = speech_ff;
      overrun_in   = overrun_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      last_in      = last_ff;
      r_in         = r_ff;
      pop_data_in  = pop_data_ff;
      pop_valid_in = pop_valid_ff;
      mul_a        = '0;
      mul_b        = '0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      root_req     = '0;
      rsp_load     = 1'b0;

      unique case (state_ff)
         agm_pkg::S_IDLE: begin
            if (req_valid) begin
               neg_in       = req_data.sample_in[agm_pkg::SAMPLE_W-1];
               mag_in       = req_data.sample_in[agm_pkg::SAMPLE_W-1]
                            ? ({1'b1, agm_pkg::SAMPLE_W'(0)} - {1'b0, req_data.sample_in})
                            : {1'b0, req_data.sample_in};
               last_in      = req_data.buffer_end;
               pop_data_in  = '0;
               pop_valid_in = 1'b0;
               unique case (req_data.cmd)
                  agm_pkg::CMD_PUSH: begin
                     state_in = agm_pkg::S_GAIN;
                  end
                  agm_pkg::CMD_POP: begin
                     if (fill != '0) begin
                        // read the oldest slot; data lands next cycle
                        ram_re    = 1'b1;
                        rd_idx_in = rd_idx_ff + 1'b1;
                        state_in  = agm_pkg::S_POP;
                     end else begin
                        state_in  = agm_pkg::S_REPLY;
                     end
                  end
                  agm_pkg::CMD_CLEAR: begin
                     wr_idx_in  = '0;
                     rd_idx_in  = '0;
                     sum_in     = '0;
                     samples_in = '0;
                     bpeak_in   = '0;
                     level_in   = '0;
                     peak_in    = '0;
                     frames_in  = '0;
                     speech_in  = '0;
                     overrun_in = 1'b0;
                     state_in   = agm_pkg::S_REPLY;
                  end
                  default: begin
                     state_in = agm_pkg::S_REPLY;  // unused command: status only
                  end
               endcase
            end
         end
         agm_pkg::S_GAIN: begin
            mul_a    = mag_ff;
            mul_b    = gain_ff;
            state_in = agm_pkg::S_ROUND;
         end
         agm_pkg::S_ROUND: begin
            r_in     = sat ? '1
                           : rounded[agm_pkg::ROUND_SHIFT +: agm_pkg::LEVEL_W];
            state_in = agm_pkg::S_SQUARE;
         end
         agm_pkg::S_SQUARE: begin
            mul_a    = agm_pkg::MAG_W'(r_ff);
            mul_b    = agm_pkg::GAIN_W'(r_ff);
            state_in = agm_pkg::S_ACCUM;
         end
         agm_pkg::S_ACCUM: begin
            // counters see every sample, whether the ring takes it or drops it
            if (frames_ff != '1) begin
               frames_in = frames_ff + 1'b1;
            end
            if ((r_ff >= thresh_ff) && (speech_ff != '1)) begin
               speech_in = speech_ff + 1'b1;
            end
            if (ring_full) begin
               overrun_in = 1'b1;
            end else begin
               ram_we    = 1'b1;
               wr_idx_in = wr_idx_ff + 1'b1;
            end
            if (finish) begin
               // close the buffer: mean of squares and its root run in u_root
               root_req.start    = 1'b1;
               root_req.dividend = sum_next;
               root_req.divisor  = samples_next;
               peak_in    = (bpeak_next > peak_ff) ? bpeak_next : peak_ff;
               sum_in     = '0;
               samples_in = '0;
               bpeak_in   = '0;
               state_in   = agm_pkg::S_ROOT;
            end else begin
               sum_in     = sum_next;
               samples_in = samples_next;
               bpeak_in   = bpeak_next;
               state_in   = agm_pkg::S_REPLY;
            end
         end
         agm_pkg::S_ROOT: begin
            if (root_rsp.done) begin
               level_in = root_rsp.root;
               state_in = agm_pkg::S_REPLY;
            end
         end
         agm_pkg::S_POP: begin
            pop_data_in  = ram_rdata;
            pop_valid_in = 1'b1;
            state_in     = agm_pkg::S_REPLY;
         end
         agm_pkg::S_REPLY: begin
            // wait for the result register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = agm_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = agm_pkg::S_IDLE;
         end
      endcase
   end

   // --------------------------------------------------------------------
   // Result register: status taken after the item's update
   // --------------------------------------------------------------------
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (rsp_load) begin
         rsp_data_in.sample_out    = pop_data_ff;
         rsp_data_in.sample_valid  = pop_valid_ff;
         rsp_data_in.rms_level     = level_ff;
         rsp_data_in.session_peak  = peak_ff;
         rsp_data_in.overrun       = overrun_ff;
         rsp_data_in.frame_count   = frames_ff;
         rsp_data_in.speech_count  = speech_ff;
         rsp_data_in.enough_speech = (speech_ff >= min_speech_ff);
         rsp_data_in.ring_fill     = agm_pkg::LEVEL_W'(fill);
      end
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ready);

   assign req_ready = (state_ff == agm_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // --------------------------------------------------------------------
   // Assertions
   // --------------------------------------------------------------------
   `AGM_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, fill <= agm_pkg::IDX_W'(agm_pkg::RING_DEPTH))

   `AGM_ASSERT_NOW(a_buffer_bound, clock, reset, 1'b1, samples_ff < agm_pkg::CNT_W'(agm_pkg::MAX_BUFFER_SAMPLES))

   `AGM_ASSERT_NEXT(a_reply_loads, clock, reset, (state_ff == agm_pkg::S_REPLY) && !rsp_valid_ff, rsp_valid_ff && (state_ff == agm_pkg::S_IDLE))

   `AGM_ASSERT_NOW(a_overrun_on_push, clock, reset, $rose(overrun_ff), $past(state_ff) == agm_pkg::S_ACCUM)

endmodule

`default_nettype wire
